// ----- hw/rtl/slp_pkg.sv -----
// Package for the subnet longest-prefix lookup block.
// Table sizing, operation codes, state codes and the structs shared by the modules.
// No dependencies.
package slp_pkg;

  localparam int unsigned TABLE_SLOTS = 32;
  localparam int unsigned IFACE_COUNT = 16;

  localparam int unsigned IDX_W   = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int unsigned SLOT_W  = 5;
  localparam int unsigned IFACE_W = 4;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned ENTRY_W = IFACE_W + 2 * ADDR_W;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FIND  = 2'd1,
    OP_CHECK = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         operation;
    logic [SLOT_W-1:0]  slot;
    logic               entry_valid;
    logic [IFACE_W-1:0] entry_iface;
    logic [ADDR_W-1:0]  entry_subnet;
    logic [ADDR_W-1:0]  entry_mask;
    logic [ADDR_W-1:0]  query_addr;
    logic [IFACE_W-1:0] query_iface;
  } req_t;

  typedef struct packed {
    logic               found;
    logic [IFACE_W-1:0] found_iface;
    logic [ADDR_W-1:0]  found_mask;
    logic               addr_valid;
  } res_t;

  typedef struct packed {
    logic [IFACE_W-1:0] iface;
    logic [ADDR_W-1:0]  subnet;
    logic [ADDR_W-1:0]  mask;
  } entry_t;

endpackage

// ----- hw/rtl/slp_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Standalone; no package dependency.
module slp_ram #(
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned WIDTH  = 68,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hw/rtl/slp_ctrl.sv -----
// Sequencer for the subnet table: slot writes, valid marks and the slot-by-slot scan.
// Uses slp_pkg and the entry RAM slp_ram.
module slp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  input  slp_pkg::req_t req_i,
  output logic          busy_o,
  input  logic          res_free_i,
  output logic          res_valid_o,
  output slp_pkg::res_t res_o
);

  localparam int unsigned IdxW = slp_pkg::IDX_W;

  slp_pkg::state_e state_q, state_d;
  logic [IdxW-1:0] cnt_q, cnt_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] pend_idx_q, pend_idx_d;
  logic [slp_pkg::TABLE_SLOTS-1:0] valid_q, valid_d;

  slp_pkg::op_e                op_q, op_d;
  logic [slp_pkg::ADDR_W-1:0]  qaddr_q, qaddr_d;
  logic [slp_pkg::IFACE_W-1:0] qif_q, qif_d;
  logic                        qif_ok_q, qif_ok_d;

  logic [slp_pkg::ADDR_W-1:0]  best_q, best_d;
  logic [slp_pkg::IFACE_W-1:0] fif_q, fif_d;
  logic                        found_q, found_d;
  logic                        avalid_q, avalid_d;

  logic            accept;
  logic            wr_en;
  logic [IdxW-1:0] wr_idx;
  logic            rd_en;
  logic [slp_pkg::ENTRY_W-1:0] rd_raw;
  slp_pkg::entry_t rd_entry;
  slp_pkg::entry_t wr_entry;
  logic            hit_valid;
  logic            net_match;
  logic            chk_match;

  assign accept = req_valid_i && (state_q == slp_pkg::ST_IDLE);
  assign busy_o = (state_q != slp_pkg::ST_IDLE);

  // Writes land at the accept edge; slot or iface out of range drops the write.
  assign wr_en = accept && (slp_pkg::op_e'(req_i.operation) == slp_pkg::OP_WRITE)
              && (32'(req_i.slot) < 32'(slp_pkg::TABLE_SLOTS))
              && (32'(req_i.entry_iface) < 32'(slp_pkg::IFACE_COUNT));
  assign wr_idx = IdxW'(req_i.slot);
  assign wr_entry = '{iface: req_i.entry_iface, subnet: req_i.entry_subnet,
                      mask: req_i.entry_mask};

  assign rd_en = (state_q == slp_pkg::ST_SCAN);

  slp_ram #(
    .DEPTH (slp_pkg::TABLE_SLOTS),
    .WIDTH (slp_pkg::ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_idx),
    .wdata_i (wr_entry),
    .re_i    (rd_en),
    .raddr_i (cnt_q),
    .rdata_o (rd_raw)
  );

  assign rd_entry  = slp_pkg::entry_t'(rd_raw);
  assign hit_valid = pend_q && valid_q[pend_idx_q];
  assign net_match = ((qaddr_q & rd_entry.mask) == rd_entry.subnet);
  assign chk_match = ((qaddr_q & rd_entry.mask) == (rd_entry.subnet & rd_entry.mask));

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    valid_d    = valid_q;
    op_d       = op_q;
    qaddr_d    = qaddr_q;
    qif_d      = qif_q;
    qif_ok_d   = qif_ok_q;
    best_d     = best_q;
    fif_d      = fif_q;
    found_d    = found_q;
    avalid_d   = avalid_q;
    res_valid_o = 1'b0;

    if (wr_en) begin
      valid_d[wr_idx] = req_i.entry_valid;
    end

    // Compare the entry read in the previous cycle.
    if (hit_valid) begin
      case (op_q)
        slp_pkg::OP_FIND: begin
          if ((rd_entry.mask > best_q) && net_match) begin
            best_d  = rd_entry.mask;
            fif_d   = rd_entry.iface;
            found_d = 1'b1;
          end
        end
        slp_pkg::OP_CHECK: begin
          if (qif_ok_q && (rd_entry.iface == qif_q) && chk_match) begin
            avalid_d = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    case (state_q)
      slp_pkg::ST_IDLE: begin
        if (accept) begin
          op_d     = slp_pkg::op_e'(req_i.operation);
          qaddr_d  = req_i.query_addr;
          qif_d    = req_i.query_iface;
          qif_ok_d = (32'(req_i.query_iface) < 32'(slp_pkg::IFACE_COUNT));
          best_d   = '0;
          fif_d    = '0;
          found_d  = 1'b0;
          avalid_d = 1'b0;
          cnt_d    = '0;
          if ((slp_pkg::op_e'(req_i.operation) == slp_pkg::OP_FIND) ||
              (slp_pkg::op_e'(req_i.operation) == slp_pkg::OP_CHECK)) begin
            state_d = slp_pkg::ST_SCAN;
          end else begin
            state_d = slp_pkg::ST_DONE;
          end
        end
      end
      slp_pkg::ST_SCAN: begin
        pend_d     = 1'b1;
        pend_idx_d = cnt_q;
        if (cnt_q == IdxW'(slp_pkg::TABLE_SLOTS - 1)) begin
          state_d = slp_pkg::ST_LAST;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      slp_pkg::ST_LAST: begin
        state_d = slp_pkg::ST_DONE;
      end
      slp_pkg::ST_DONE: begin
        if (res_free_i) begin
          res_valid_o = 1'b1;
          state_d     = slp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = slp_pkg::ST_IDLE;
      end
    endcase
  end

  assign res_o = '{found: found_q, found_iface: fif_q, found_mask: best_q,
                   addr_valid: avalid_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= slp_pkg::ST_IDLE;
      cnt_q   <= '0;
      pend_q  <= 1'b0;
      valid_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      pend_q  <= pend_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    op_q       <= op_d;
    qaddr_q    <= qaddr_d;
    qif_q      <= qif_d;
    qif_ok_q   <= qif_ok_d;
    best_q     <= best_d;
    fif_q      <= fif_d;
    found_q    <= found_d;
    avalid_q   <= avalid_d;
  end

endmodule

// ----- hw/rtl/subnet_longest_prefix_lookup.sv -----
// Top level of the subnet longest-prefix lookup block.
// Uses slp_pkg and slp_ctrl; holds the result output register.
//
// One item at a time. A write or an unused code goes from accept straight to the done
// state. A find or a check first scans the entry RAM, one slot read per cycle through its
// single read port, then compares the last slot in the last-slot state. Input stall drops
// the cycle after a result is handed to the output register, even if that result is still
// stalled. A finished result waits in the sequencer while the output register holds a
// stalled one. Valid marks reset to cleared, so no clearing pass is needed.
module subnet_longest_prefix_lookup (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  operation_i,
  input  logic [slp_pkg::SLOT_W-1:0]  slot_i,
  input  logic                        entry_valid_i,
  input  logic [slp_pkg::IFACE_W-1:0] entry_iface_i,
  input  logic [slp_pkg::ADDR_W-1:0]  entry_subnet_i,
  input  logic [slp_pkg::ADDR_W-1:0]  entry_mask_i,
  input  logic [slp_pkg::ADDR_W-1:0]  query_addr_i,
  input  logic [slp_pkg::IFACE_W-1:0] query_iface_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        found_o,
  output logic [slp_pkg::IFACE_W-1:0] found_iface_o,
  output logic [slp_pkg::ADDR_W-1:0]  found_mask_o,
  output logic                        addr_valid_o
);

  slp_pkg::req_t req;
  slp_pkg::res_t res;
  slp_pkg::res_t out_q, out_d;
  logic          out_valid_q, out_valid_d;
  logic          res_valid;
  logic          res_free;
  logic          busy;

  assign req = '{operation: operation_i, slot: slot_i, entry_valid: entry_valid_i,
                 entry_iface: entry_iface_i, entry_subnet: entry_subnet_i,
                 entry_mask: entry_mask_i, query_addr: query_addr_i,
                 query_iface: query_iface_i};

  // Output register is free when empty or being taken this cycle.
  assign res_free = !out_valid_q || !out_stall_i;

  slp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .req_i       (req),
    .busy_o      (busy),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign in_stall_o = busy;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = out_q.found;
  assign found_iface_o = out_q.found_iface;
  assign found_mask_o  = out_q.found_mask;
  assign addr_valid_o  = out_q.addr_valid;

endmodule

// ----- hw/rtl/slp_checker.sv -----
// Port-level checks for subnet_longest_prefix_lookup, attached by bind.
// Uses slp_pkg for port widths.
module slp_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        found_o,
  input logic [slp_pkg::IFACE_W-1:0] found_iface_o,
  input logic [slp_pkg::ADDR_W-1:0]  found_mask_o,
  input logic                        addr_valid_o
);

  // stalled result item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(found_o)
      && $stable(found_iface_o) && $stable(found_mask_o) && $stable(addr_valid_o))
    else $error("stalled result item changed");

  // an accepted item keeps the block busy for at least the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after accept");

  // find and check answers never appear together
  a_one_answer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(found_o && addr_valid_o))
    else $error("found and addr_valid both set");

  // a miss reports zeros; a hit never carries a zero mask
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (found_iface_o == '0) && (found_mask_o == '0))
    else $error("miss with nonzero iface or mask");

  a_hit_mask: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && found_o |-> (found_mask_o != '0))
    else $error("hit with zero mask");

endmodule

bind subnet_longest_prefix_lookup slp_checker u_slp_checker (.*);
